// ===== src/format_spec_parser_defines.svh =====
// assertion macros for the format specification parser
// used by format_spec_parser.sv, no other dependencies
`ifndef FORMAT_SPEC_PARSER_DEFINES_SVH
`define FORMAT_SPEC_PARSER_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication, checked on every rising clock edge out of reset
`define FSP_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("format_spec_parser: same-cycle check failed");
// next-cycle implication
`define FSP_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("format_spec_parser: next-cycle check failed");
`else
`define FSP_ASSERT_IMP(label, ante, cons)
`define FSP_ASSERT_NXT(label, ante, cons)
`endif

`endif

// ===== src/fsp_pkg.sv =====
// types, codes and character helpers for the format specification parser
// no dependencies
`timescale 1ns / 1ps

package fsp_pkg;

    typedef enum logic [8:0] {
        PH_START    = 9'b000000001,
        PH_FLAG     = 9'b000000010,
        PH_WIDTH    = 9'b000000100,
        PH_PREC0    = 9'b000001000,
        PH_PREC     = 9'b000010000,
        PH_SUBTYPE  = 9'b000100000,
        PH_DONE     = 9'b001000000,
        PH_BADTOK   = 9'b010000000,
        PH_OVERFLOW = 9'b100000000
    } t_phase;

    typedef logic [7:0] t_char;

    // request operations
    localparam logic OP_FEED  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    // outcome codes
    localparam logic [1:0] OC_RUN      = 2'd0;
    localparam logic [1:0] OC_DONE     = 2'd1;
    localparam logic [1:0] OC_BADTOK   = 2'd2;
    localparam logic [1:0] OC_OVERFLOW = 2'd3;

    // flag bit positions
    localparam int FL_LEFT  = 0;
    localparam int FL_SIGN  = 1;
    localparam int FL_ZERO  = 2;
    localparam int FL_BLANK = 3;
    localparam int FL_ALT   = 4;

    localparam t_char CH_PERCENT = 8'h25;
    localparam t_char CH_MINUS   = 8'h2D;
    localparam t_char CH_PLUS    = 8'h2B;
    localparam t_char CH_ZERO    = 8'h30;
    localparam t_char CH_NINE    = 8'h39;
    localparam t_char CH_SPACE   = 8'h20;
    localparam t_char CH_HASH    = 8'h23;
    localparam t_char CH_DOT     = 8'h2E;
    localparam t_char CH_LOW_V   = 8'h76;
    localparam t_char CH_UP_C    = 8'h43;
    localparam t_char CH_UP_F    = 8'h46;
    localparam t_char CH_UP_H    = 8'h48;

    function automatic logic is_digit(input t_char c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // '%' and letters, less f i o q J K L N Q
    function automatic logic type_ok(input t_char c);
        logic ok;
        case (c) inside
            CH_PERCENT:                      ok = 1'b1;
            8'h66, 8'h69, 8'h6F, 8'h71:      ok = 1'b0;
            8'h4A, 8'h4B, 8'h4C, 8'h4E, 8'h51: ok = 1'b0;
            [8'h61:8'h7A], [8'h41:8'h5A]:    ok = 1'b1;
            default:                         ok = 1'b0;
        endcase
        return ok;
    endfunction

    function automatic logic subtype_ok(input t_char c);
        return (c == CH_UP_C) || (c == CH_UP_F) || (c == CH_UP_H);
    endfunction

    function automatic logic [1:0] outcome_of(input t_phase ph);
        logic [1:0] oc;
        case (ph)
            PH_DONE:     oc = OC_DONE;
            PH_BADTOK:   oc = OC_BADTOK;
            PH_OVERFLOW: oc = OC_OVERFLOW;
            default:     oc = OC_RUN;
        endcase
        return oc;
    endfunction

endpackage

// ===== src/format_spec_parser.sv =====
// printf-style conversion specification parser, one character per request
// depends on fsp_pkg and format_spec_parser_defines.svh
//
// Usage: each input request carries i_op and i_char_in. A feed request (op 0)
// pushes one character through the parse of %[flags][width][.precision]type[subtype];
// a clear request (op 1) returns the parser to its start state. Every request
// produces exactly one result holding the accepted bit, the outcome code and the
// flags, width, precision, type and subtype gathered so far.
// Timing: a request is captured in the input register at the edge it is taken;
// its result then moves from the input register into the result register, which
// raises o_valid, once the result side is free. Throughput: one request per cycle
// while the result side does not stall; next-state and multiply-by-ten are combinational.
// Stall: with i_stall high a valid result register holds; one more request can still
// sit in the input register, after which o_stall rises until the result is taken.
// Reset: synchronous, active low; clears both valid flags and all parse state.
// Width and precision are NUMBER_BITS wide internally and saturate with the
// overflow outcome; the result fields carry their low 16 bits.
`timescale 1ns / 1ps

`include "format_spec_parser_defines.svh"

module format_spec_parser #(
    parameter int NUMBER_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic                 i_op,
    input  fsp_pkg::t_char       i_char_in,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic                 o_accepted,
    output logic [1:0]           o_outcome,
    output logic [4:0]           o_flag_bits,
    output logic [15:0]          o_field_width,
    output logic [15:0]          o_field_precision,
    output fsp_pkg::t_char       o_type_char,
    output fsp_pkg::t_char       o_subtype_char
);
    import fsp_pkg::*;

    localparam int SumBits = NUMBER_BITS + 4;

    // input register
    logic   r_in_valid;
    logic   r_op;
    t_char  r_char;

    // parse state, doubles as the result register
    logic                   r_out_valid;
    logic                   r_acc,   n_acc;
    t_phase                 r_phase, n_phase;
    logic [4:0]             r_flags, n_flags;
    logic [NUMBER_BITS-1:0] r_width, n_width;
    logic [NUMBER_BITS-1:0] r_prec,  n_prec;
    t_char                  r_type,  n_type;
    t_char                  r_sub,   n_sub;

    logic                   out_free;
    logic                   fire;
    logic [NUMBER_BITS-1:0] num_src;
    logic [SumBits-1:0]     num_sum;
    logic                   num_ovf;
    logic [3:0]             digit;

    assign out_free = !r_out_valid || !i_stall;
    assign fire     = r_in_valid && out_free;
    assign o_stall  = r_in_valid && !out_free;

    assign digit   = r_char[3:0];
    assign num_src = (r_phase == PH_PREC) ? r_prec : r_width;
    // n*10 + d as (n << 3) + (n << 1) + d
    assign num_sum = ({4'b0, num_src} << 3) + ({4'b0, num_src} << 1)
                   + SumBits'(digit);
    assign num_ovf = |num_sum[SumBits-1:NUMBER_BITS];

    always_comb begin
        n_acc   = 1'b0;
        n_phase = r_phase;
        n_flags = r_flags;
        n_width = r_width;
        n_prec  = r_prec;
        n_type  = r_type;
        n_sub   = r_sub;
        if (r_op == OP_CLEAR) begin
            n_phase = PH_START;
            n_flags = '0;
            n_width = '0;
            n_prec  = '0;
            n_type  = '0;
            n_sub   = '0;
        end else begin
            case (r_phase)
                PH_START: begin
                    if (r_char == CH_PERCENT) begin
                        n_acc   = 1'b1;
                        n_phase = PH_FLAG;
                        n_flags = '0;
                        n_width = '0;
                        n_prec  = '0;
                        n_type  = '0;
                        n_sub   = '0;
                    end else begin
                        n_phase = PH_BADTOK;
                    end
                end
                PH_FLAG, PH_WIDTH, PH_PREC0, PH_PREC: begin
                    n_acc = 1'b1;
                    if (r_phase == PH_FLAG && r_char == CH_MINUS) begin
                        n_flags[FL_LEFT] = 1'b1;
                    end else if (r_phase == PH_FLAG && r_char == CH_PLUS) begin
                        n_flags[FL_SIGN] = 1'b1;
                    end else if (r_phase == PH_FLAG && r_char == CH_ZERO) begin
                        n_flags[FL_ZERO] = 1'b1;
                    end else if (r_phase == PH_FLAG && r_char == CH_SPACE) begin
                        n_flags[FL_BLANK] = 1'b1;
                    end else if (r_phase == PH_FLAG && r_char == CH_HASH) begin
                        n_flags[FL_ALT] = 1'b1;
                    end else if ((r_phase == PH_FLAG || r_phase == PH_WIDTH)
                                 && r_char == CH_DOT) begin
                        n_phase = PH_PREC0;
                    end else if (is_digit(r_char)) begin
                        case (r_phase)
                            PH_FLAG: begin
                                n_phase = PH_WIDTH;
                                n_width = NUMBER_BITS'(digit);
                            end
                            PH_PREC0: begin
                                n_phase = PH_PREC;
                                n_prec  = NUMBER_BITS'(digit);
                            end
                            default: begin
                                // accumulate into width or precision, saturating
                                if (num_ovf) begin
                                    n_acc   = 1'b0;
                                    n_phase = PH_OVERFLOW;
                                end
                                if (r_phase == PH_PREC) begin
                                    n_prec = num_ovf ? '1 : num_sum[NUMBER_BITS-1:0];
                                end else begin
                                    n_width = num_ovf ? '1 : num_sum[NUMBER_BITS-1:0];
                                end
                            end
                        endcase
                    end else begin
                        // anything else is the type character
                        n_type = r_char;
                        if (r_char == CH_LOW_V) begin
                            n_phase = PH_SUBTYPE;
                        end else begin
                            n_acc   = 1'b0;
                            n_phase = type_ok(r_char) ? PH_DONE : PH_BADTOK;
                        end
                    end
                end
                PH_SUBTYPE: begin
                    n_sub   = r_char;
                    n_phase = subtype_ok(r_char) ? PH_DONE : PH_BADTOK;
                end
                default: begin
                    // terminal phases hold everything
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
        if (!o_stall) begin
            r_op   <= i_op;
            r_char <= i_char_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_acc       <= 1'b0;
            r_phase     <= PH_START;
            r_flags     <= '0;
            r_width     <= '0;
            r_prec      <= '0;
            r_type      <= '0;
            r_sub       <= '0;
        end else begin
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
            if (fire) begin
                r_acc   <= n_acc;
                r_phase <= n_phase;
                r_flags <= n_flags;
                r_width <= n_width;
                r_prec  <= n_prec;
                r_type  <= n_type;
                r_sub   <= n_sub;
            end
        end
    end

    assign o_valid           = r_out_valid;
    assign o_accepted        = r_acc;
    assign o_outcome         = outcome_of(r_phase);
    assign o_flag_bits       = r_flags;
    assign o_field_width     = 16'(r_width);
    assign o_field_precision = 16'(r_prec);
    assign o_type_char       = r_type;
    assign o_subtype_char    = r_sub;

    `FSP_ASSERT_IMP(a_stall_needs_item, o_stall, r_in_valid)
    `FSP_ASSERT_NXT(a_clear_zeroes, fire && r_op == OP_CLEAR, !o_accepted && o_outcome == OC_RUN && o_field_width == '0 && o_type_char == '0)
    `FSP_ASSERT_NXT(a_terminal_quiet, fire && r_op == OP_FEED && (r_phase == PH_DONE || r_phase == PH_BADTOK || r_phase == PH_OVERFLOW), !o_accepted && $stable(r_phase))
    `FSP_ASSERT_IMP(a_done_not_accepted, r_out_valid && o_outcome != OC_RUN, !o_accepted)

endmodule

// ===== tb/tb_format_spec_parser.sv =====
// self-checking testbench for the printf-style format specification parser
// depends on fsp_pkg and format_spec_parser; a scoreboard class predicts each result
`timescale 1ns / 1ps

module tb_format_spec_parser;
    import fsp_pkg::*;

    localparam int          SPEC_NUM_BITS = 16;
    localparam int unsigned SPEC_NUM_MAX  = (32'd1 << SPEC_NUM_BITS) - 1;
    localparam int          RANDOM_ITEMS  = 550;

    typedef struct {
        logic        accepted;
        logic [1:0]  outcome;
        logic [4:0]  flags;
        logic [15:0] width;
        logic [15:0] precision;
        t_char       type_ch;
        t_char       subtype_ch;
    } t_spec_result;

    // tracks the parse state and the results still owed by the block
    class t_spec_scoreboard;
        t_phase       phase;
        logic [4:0]   flags;
        int unsigned  width_acc;
        int unsigned  prec_acc;
        t_char        type_ch;
        t_char        subtype_ch;
        t_spec_result pending[$];
        int           errors;

        function new();
            errors = 0;
            clear_state();
        endfunction

        function void clear_state();
            phase      = PH_START;
            flags      = '0;
            width_acc  = 0;
            prec_acc   = 0;
            type_ch    = '0;
            subtype_ch = '0;
        endfunction

        function bit is_numeral(t_char c);
            return c >= CH_ZERO && c <= CH_NINE;
        endfunction

        function bit type_letter_ok(t_char c);
            if (c == CH_PERCENT)
                return 1'b1;
            if (c >= "a" && c <= "z")
                return !(c == "f" || c == "i" || c == "o" || c == "q");
            if (c >= "A" && c <= "Z")
                return !(c == "J" || c == "K" || c == "L" || c == "N" || c == "Q");
            return 1'b0;
        endfunction

        function bit take_type(t_char c);
            type_ch = c;
            if (c == CH_LOW_V) begin
                phase = PH_SUBTYPE;
                return 1'b1;
            end
            phase = type_letter_ok(c) ? PH_DONE : PH_BADTOK;
            return 1'b0;
        endfunction

        // saturates and moves to overflow once the number no longer fits
        function bit add_decimal(inout int unsigned acc, input t_char c);
            int unsigned v;
            v = acc * 10 + (c - CH_ZERO);
            if (v > SPEC_NUM_MAX) begin
                acc   = SPEC_NUM_MAX;
                phase = PH_OVERFLOW;
                return 1'b0;
            end
            acc = v;
            return 1'b1;
        endfunction

        function bit feed_char(t_char c);
            case (phase)
                PH_START: begin
                    if (c == CH_PERCENT) begin
                        clear_state();
                        phase = PH_FLAG;
                        return 1'b1;
                    end
                    phase = PH_BADTOK;
                    return 1'b0;
                end
                PH_FLAG: begin
                    case (c)
                        CH_MINUS: begin flags[FL_LEFT]  = 1'b1; return 1'b1; end
                        CH_PLUS:  begin flags[FL_SIGN]  = 1'b1; return 1'b1; end
                        CH_ZERO:  begin flags[FL_ZERO]  = 1'b1; return 1'b1; end
                        CH_SPACE: begin flags[FL_BLANK] = 1'b1; return 1'b1; end
                        CH_HASH:  begin flags[FL_ALT]   = 1'b1; return 1'b1; end
                        CH_DOT:   begin phase = PH_PREC0; return 1'b1; end
                        default: begin
                            if (is_numeral(c)) begin
                                phase     = PH_WIDTH;
                                width_acc = c - CH_ZERO;
                                return 1'b1;
                            end
                            return take_type(c);
                        end
                    endcase
                end
                PH_WIDTH: begin
                    if (is_numeral(c))
                        return add_decimal(width_acc, c);
                    if (c == CH_DOT) begin
                        phase = PH_PREC0;
                        return 1'b1;
                    end
                    return take_type(c);
                end
                PH_PREC0: begin
                    if (is_numeral(c)) begin
                        phase    = PH_PREC;
                        prec_acc = c - CH_ZERO;
                        return 1'b1;
                    end
                    return take_type(c);
                end
                PH_PREC: begin
                    if (is_numeral(c))
                        return add_decimal(prec_acc, c);
                    return take_type(c);
                end
                PH_SUBTYPE: begin
                    subtype_ch = c;
                    phase = (c == CH_UP_C || c == CH_UP_F || c == CH_UP_H) ? PH_DONE : PH_BADTOK;
                    return 1'b0;
                end
                default: return 1'b0;
            endcase
        endfunction

        function void note_request(logic op, t_char c);
            t_spec_result r;
            logic         acc;
            if (op == OP_CLEAR) begin
                clear_state();
                acc = 1'b0;
            end else begin
                acc = feed_char(c);
            end
            r.accepted = acc;
            case (phase)
                PH_DONE:     r.outcome = OC_DONE;
                PH_BADTOK:   r.outcome = OC_BADTOK;
                PH_OVERFLOW: r.outcome = OC_OVERFLOW;
                default:     r.outcome = OC_RUN;
            endcase
            r.flags      = flags;
            r.width      = width_acc[15:0];
            r.precision  = prec_acc[15:0];
            r.type_ch    = type_ch;
            r.subtype_ch = subtype_ch;
            pending.push_back(r);
        endfunction

        function void compare_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
            if (exp_v !== act_v) begin
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_result(t_spec_result got);
            t_spec_result exp_r;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result, expected none, got outcome %0d",
                         $time, got.outcome);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            compare_field("accepted", exp_r.accepted, got.accepted);
            compare_field("outcome", exp_r.outcome, got.outcome);
            compare_field("flag_bits", exp_r.flags, got.flags);
            compare_field("field_width", exp_r.width, got.width);
            compare_field("field_precision", exp_r.precision, got.precision);
            compare_field("type_char", exp_r.type_ch, got.type_ch);
            compare_field("subtype_char", exp_r.subtype_ch, got.subtype_ch);
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic        i_op;
    t_char       i_char_in;
    logic        o_valid;
    logic        i_stall;
    logic        o_accepted;
    logic [1:0]  o_outcome;
    logic [4:0]  o_flag_bits;
    logic [15:0] o_field_width;
    logic [15:0] o_field_precision;
    t_char       o_type_char;
    t_char       o_subtype_char;

    t_spec_scoreboard board = new();

    bit sender_idle   = 1'b1;
    bit receiver_idle = 1'b1;
    bit long_hold_req = 1'b0;
    bit long_hold_done = 1'b0;
    int items_sent    = 0;

    format_spec_parser #(.NUMBER_BITS(SPEC_NUM_BITS)) uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_op              (i_op),
        .i_char_in         (i_char_in),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_accepted        (o_accepted),
        .o_outcome         (o_outcome),
        .o_flag_bits       (o_flag_bits),
        .o_field_width     (o_field_width),
        .o_field_precision (o_field_precision),
        .o_type_char       (o_type_char),
        .o_subtype_char    (o_subtype_char)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // called at a falling edge, returns at a falling edge once the request is taken
    task automatic send_request(input logic op, input t_char c);
        if (sender_idle && $urandom_range(0, 5) == 0) begin
            i_valid = 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge i_clk);
        end
        i_valid   = 1'b1;
        i_op      = op;
        i_char_in = c;
        do @(posedge i_clk); while (o_stall);
        board.note_request(op, c);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic feed_text(input string s);
        for (int k = 0; k < s.len(); k++)
            send_request(OP_FEED, t_char'(s[k]));
    endtask

    function automatic t_char random_letter();
        if ($urandom_range(0, 1))
            return t_char'("a" + $urandom_range(0, 25));
        return t_char'("A" + $urandom_range(0, 25));
    endfunction

    // mostly well-formed specifications with random content, some noise and cut-off ones
    task automatic run_random_spec();
        t_char seq[$];
        string flag_set;
        int    kind;
        int    sel;
        flag_set = "-+0 #";
        kind = $urandom_range(0, 9);
        if (kind != 0)
            send_request(OP_CLEAR, t_char'($urandom_range(0, 255)));
        if (kind == 1) begin
            repeat ($urandom_range(1, 4))
                seq.push_back(t_char'($urandom_range(0, 255)));
        end else begin
            seq.push_back(CH_PERCENT);
            repeat ($urandom_range(0, 4))
                seq.push_back(t_char'(flag_set[$urandom_range(0, 4)]));
            if ($urandom_range(0, 2) != 0) begin
                seq.push_back(t_char'("1" + $urandom_range(0, 8)));
                repeat ($urandom_range(0, 5))
                    seq.push_back(t_char'(CH_ZERO + $urandom_range(0, 9)));
            end
            if ($urandom_range(0, 1)) begin
                seq.push_back(CH_DOT);
                repeat ($urandom_range(0, 6))
                    seq.push_back(t_char'(CH_ZERO + $urandom_range(0, 9)));
            end
            sel = $urandom_range(0, 6);
            case (sel)
                0, 1, 2: seq.push_back(random_letter());
                3, 4: begin
                    seq.push_back(CH_LOW_V);
                    case ($urandom_range(0, 4))
                        0:       seq.push_back(CH_UP_C);
                        1:       seq.push_back(CH_UP_F);
                        2:       seq.push_back(CH_UP_H);
                        3:       seq.push_back(random_letter());
                        default: seq.push_back(t_char'($urandom_range(0, 255)));
                    endcase
                end
                5:       seq.push_back(CH_PERCENT);
                default: seq.push_back(t_char'($urandom_range(0, 255)));
            endcase
            if (kind == 2)
                seq = seq[0:$urandom_range(0, seq.size() - 1)];
        end
        foreach (seq[k])
            send_request(OP_FEED, seq[k]);
        // one character after the end, normally ignored
        if ($urandom_range(0, 3) == 0)
            send_request(OP_FEED, t_char'($urandom_range(0, 255)));
    endtask

    // result side hold-offs
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold_req) begin
                i_stall = 1'b1;
                repeat (200) @(negedge i_clk);
                i_stall        = 1'b0;
                long_hold_req  = 1'b0;
                long_hold_done = 1'b1;
            end else if (receiver_idle && i_rst_n && $urandom_range(0, 5) == 0) begin
                i_stall = 1'b1;
                repeat ($urandom_range(1, 15)) @(negedge i_clk);
                i_stall = 1'b0;
            end
        end
    end

    initial begin
        t_spec_result got;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                got.accepted   = o_accepted;
                got.outcome    = o_outcome;
                got.flags      = o_flag_bits;
                got.width      = o_field_width;
                got.precision  = o_field_precision;
                got.type_ch    = o_type_char;
                got.subtype_ch = o_subtype_char;
                board.check_result(got);
            end
        end
    end

    initial begin
        #3_000_000;
        $display("[format_spec_parser] ERROR");
        $finish;
    end

    initial begin
        int drain_cycles;
        i_rst_n   = 1'b0;
        i_valid   = 1'b0;
        i_op      = OP_FEED;
        i_char_in = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // full flag set, width 9, largest precision that still fits
        feed_text("%-+0 #9.65535x");
        // empty precision then a bad subtype
        send_request(OP_CLEAR, 8'hFF);
        feed_text("%.vQ");
        // first character not a percent sign
        send_request(OP_CLEAR, 8'h00);
        send_request(OP_FEED, 8'hFF);
        // width too large
        send_request(OP_CLEAR, 8'h5A);
        feed_text("%99999");

        while (items_sent < RANDOM_ITEMS + 25) begin
            sender_idle = ($urandom_range(0, 2) != 0);
            receiver_idle = ($urandom_range(0, 2) != 0);
            if (items_sent > 200 && !long_hold_done && !long_hold_req)
                long_hold_req = 1'b1;
            if (items_sent > RANDOM_ITEMS - 80) begin
                sender_idle   = 1'b0;
                receiver_idle = 1'b0;
            end
            run_random_spec();
        end
        i_valid = 1'b0;

        drain_cycles = 0;
        while (board.pending.size() != 0 && drain_cycles < 5000) begin
            @(posedge i_clk);
            drain_cycles++;
        end
        repeat (6) @(posedge i_clk);
        if (board.pending.size() != 0) begin
            $display("%0t: %0d results missing, expected 0 outstanding",
                     $time, board.pending.size());
            board.errors++;
        end
        if (board.errors == 0)
            $display("[format_spec_parser] OK");
        else
            $display("[format_spec_parser] ERROR");
        $finish;
    end

endmodule
